// ----- design/quaternion_accumulator_unit_defines.svh -----
// Assertion macros used by the accumulator unit design file.
`ifndef QUATERNION_ACCUMULATOR_UNIT_DEFINES_SVH
`define QUATERNION_ACCUMULATOR_UNIT_DEFINES_SVH

// Check an implication on every clock edge outside reset.
`define QAU_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that an implication's consequent holds in the cycle after its antecedent.
`define QAU_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/qau_pkg.sv -----
package qau_pkg;

    localparam int unsigned CompW = 16;
    localparam int unsigned NormW = 33;

    typedef logic [2:0] t_opcode;
    typedef logic [1:0] t_status;

    localparam t_opcode OP_LOAD  = 3'd0;
    localparam t_opcode OP_LMUL  = 3'd1;
    localparam t_opcode OP_RMUL  = 3'd2;
    localparam t_opcode OP_INV   = 3'd3;
    localparam t_opcode OP_CONJ  = 3'd4;
    localparam t_opcode OP_READ  = 3'd5;

    localparam t_status ST_OK   = 2'd0;
    localparam t_status ST_SAT  = 2'd1;
    localparam t_status ST_ZERO = 2'd2;

    localparam logic signed [CompW-1:0] QOne = 16'sd16384;

    typedef struct packed {
        t_opcode                   opcode;
        logic signed [CompW-1:0]   in_w;
        logic signed [CompW-1:0]   in_x;
        logic signed [CompW-1:0]   in_y;
        logic signed [CompW-1:0]   in_z;
    } t_in_item;

    typedef struct packed {
        logic signed [CompW-1:0]   out_w;
        logic signed [CompW-1:0]   out_x;
        logic signed [CompW-1:0]   out_y;
        logic signed [CompW-1:0]   out_z;
        logic [NormW-1:0]          norm_squared;
        t_status                   status;
    } t_out_item;

    // Clamp a wide signed value to 16 bits.
    function automatic logic signed [CompW-1:0] sat16(input logic signed [47:0] v);
        if (v > 48'sd32767) begin
            return 16'sh7fff;
        end else if (v < -48'sd32768) begin
            return 16'sh8000;
        end
        return v[CompW-1:0];
    endfunction

    function automatic logic is_sat16(input logic signed [47:0] v);
        return (v > 48'sd32767) || (v < -48'sd32768);
    endfunction

endpackage

// ----- design/qau_if.sv -----
interface qau_in_if (input logic i_clk);
    logic               valid;
    logic               ready;
    qau_pkg::t_in_item  data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface qau_out_if (input logic i_clk);
    logic               valid;
    logic               ready;
    qau_pkg::t_out_item data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ----- design/quaternion_accumulator_unit.sv -----
// Quaternion accumulator: one Q2.14 accumulator quaternion updated by load,
// left/right Hamilton product, invert, conjugate or read, one transaction at a
// time. One shared 17x17 multiplier serves the products and the squared norm,
// and one shared restoring divider serves the invert. A multiply runs the
// product steps, then the norm steps, then the result step; an invert runs
// the norm steps, four divisions, the norm steps again and the result step.
// Load, conjugate, read and an invert of zero norm run only the norm steps
// and the result step. A new transaction can be taken once the result is
// posted, even while that result waits for the sink; a later result holds in
// the done state until the result register is free. Reset gives the identity
// quaternion.
`include "quaternion_accumulator_unit_defines.svh"

module quaternion_accumulator_unit (
    input  logic    i_clk,
    input  logic    i_rst_n,
    qau_in_if.sink  i_in,
    qau_out_if.source o_out
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_PROD = 3'd1;
    localparam logic [2:0] S_NORM = 3'd2;
    localparam logic [2:0] S_DIV  = 3'd3;
    localparam logic [2:0] S_DONE = 3'd4;

    logic [2:0]                 r_state, n_state;
    logic [3:0]                 r_cnt, n_cnt;
    logic [4:0]                 r_dcnt, n_dcnt;
    qau_pkg::t_opcode           r_op;
    logic signed [15:0]         r_acc [4];
    logic signed [15:0]         r_opq [4];
    logic signed [15:0]         r_res [4];
    logic signed [34:0]         r_sum;
    logic [32:0]                r_norm;
    logic                       r_sat;
    logic [1:0]                 r_stat;
    logic                       r_ovalid, n_ovalid;
    qau_pkg::t_out_item         r_odata;
    logic [32:0]                r_rem;
    logic [29:0]                r_quo;
    logic [29:0]                r_dividend;

    logic                       in_fire;
    logic                       out_free;
    logic signed [16:0]         mul_a, mul_b;
    logic signed [33:0]         mul_p;
    logic [1:0]                 comp, term;
    logic [1:0]                 pidx, qidx;
    logic                       neg;
    logic signed [34:0]         rnd;
    logic signed [15:0]         rnd_sat;
    logic                       rnd_ovf;
    logic                       conj_sat;
    logic [1:0]                 didx;
    logic signed [16:0]         dval;
    logic [15:0]                dmag;
    logic [33:0]                rtrial;
    logic [32:0]                half;
    logic [29:0]                qfin;
    logic [32:0]                rfin;
    logic [30:0]                qrnd;
    logic [20:0]                qcap;
    logic                       qneg;
    logic signed [47:0]         qsgn;
    logic signed [15:0]         div_res;
    logic                       div_ovf;
    logic                       zero_stat;
    logic                       norm_zero;

    assign in_fire = i_in.valid && i_in.ready;
    assign out_free = !r_ovalid || o_out.ready;
    assign i_in.ready = (r_state == S_IDLE);
    assign o_out.valid = r_ovalid;
    assign o_out.data = r_odata;

    assign comp = r_cnt[3:2];
    assign term = r_cnt[1:0];

    always_comb begin
        qidx = term ^ comp;
        neg = 1'b0;
        unique case ({comp, term})
            4'b00_01, 4'b00_10, 4'b00_11: neg = 1'b1;
            4'b01_11: neg = 1'b1;
            4'b10_01: neg = 1'b1;
            4'b11_10: neg = 1'b1;
            default: neg = 1'b0;
        endcase
    end

    always_comb begin
        pidx = term;
        mul_a = '0;
        mul_b = '0;
        if (r_state == S_PROD) begin
            if (r_op == qau_pkg::OP_LMUL) begin
                mul_a = 17'(r_opq[pidx]);
                mul_b = 17'(r_acc[qidx]);
            end else begin
                mul_a = 17'(r_acc[pidx]);
                mul_b = 17'(r_opq[qidx]);
            end
            if (neg) begin
                mul_a = -mul_a;
            end
        end else begin
            mul_a = 17'(r_acc[r_cnt[1:0]]);
            mul_b = 17'(r_acc[r_cnt[1:0]]);
        end
    end

    assign mul_p = mul_a * mul_b;
    assign rnd = (r_sum + 35'(mul_p) + 35'sd8192) >>> 14;
    assign rnd_sat = qau_pkg::sat16(48'(rnd));
    assign rnd_ovf = qau_pkg::is_sat16(48'(rnd));
    assign conj_sat = (r_acc[1] == 16'sh8000) || (r_acc[2] == 16'sh8000)
                      || (r_acc[3] == 16'sh8000);

    always_comb begin
        didx = (r_state == S_DIV) ? r_cnt[1:0] + 2'd1 : 2'd0;
        dval = 17'(r_acc[didx]);
        dmag = 16'(dval < 0 ? -dval : dval);
    end

    assign rtrial = {r_rem, r_dividend[29]} - {1'b0, r_norm};
    assign half = r_norm >> 1;

    always_comb begin
        qfin = {r_quo[28:0], ~rtrial[33]};
        rfin = rtrial[33] ? {r_rem[31:0], r_dividend[29]} : rtrial[32:0];
        qrnd = {1'b0, qfin} + ((rfin >= r_norm - half) ? 31'd1 : 31'd0);
        qcap = (qrnd > 31'd1048576) ? 21'd1048576 : qrnd[20:0];
        // Invert: w keeps sign, vector parts flip sign.
        qneg = (r_cnt[1:0] == 2'd0) ? r_acc[0][15]
             : (!r_acc[r_cnt[1:0]][15] && r_acc[r_cnt[1:0]] != '0);
        if (qneg) begin
            qsgn = -48'(signed'({1'b0, qcap}));
        end else begin
            qsgn = 48'(signed'({1'b0, qcap}));
        end
    end

    assign div_res = qau_pkg::sat16(qsgn);
    assign div_ovf = qau_pkg::is_sat16(qsgn);

    always_comb begin
        n_state = r_state;
        n_cnt = r_cnt;
        n_dcnt = r_dcnt;
        n_ovalid = r_ovalid;
        if (o_out.valid && o_out.ready) begin
            n_ovalid = 1'b0;
        end
        unique case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    n_cnt = '0;
                    if (i_in.data.opcode == qau_pkg::OP_LMUL
                        || i_in.data.opcode == qau_pkg::OP_RMUL) begin
                        n_state = S_PROD;
                    end else begin
                        n_state = S_NORM;
                    end
                end
            end
            S_PROD: begin
                n_cnt = r_cnt + 4'd1;
                if (r_cnt == 4'd15) begin
                    n_state = S_NORM;
                end
            end
            S_NORM: begin
                n_cnt = r_cnt + 4'd1;
                if (r_cnt == 4'd4) begin
                    n_cnt = '0;
                    n_dcnt = '0;
                    if (r_op == qau_pkg::OP_INV && r_norm != '0) begin
                        n_state = S_DIV;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_DIV: begin
                n_dcnt = r_dcnt + 5'd1;
                if (r_dcnt == 5'd29) begin
                    n_dcnt = '0;
                    n_cnt = r_cnt + 4'd1;
                    if (r_cnt == 4'd3) begin
                        n_cnt = '0;
                        n_state = S_NORM;
                    end
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_ovalid = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt <= '0;
            r_dcnt <= '0;
            r_ovalid <= 1'b0;
            r_acc[0] <= qau_pkg::QOne;
            r_acc[1] <= '0;
            r_acc[2] <= '0;
            r_acc[3] <= '0;
            r_op <= qau_pkg::OP_READ;
            r_sat <= 1'b0;
            r_stat <= qau_pkg::ST_OK;
        end else begin
            r_state <= n_state;
            r_cnt <= n_cnt;
            r_dcnt <= n_dcnt;
            r_ovalid <= n_ovalid;
            unique case (r_state)
                S_IDLE: begin
                    if (in_fire) begin
                        r_op <= i_in.data.opcode;
                        r_opq[0] <= i_in.data.in_w;
                        r_opq[1] <= i_in.data.in_x;
                        r_opq[2] <= i_in.data.in_y;
                        r_opq[3] <= i_in.data.in_z;
                        r_sat <= (i_in.data.opcode == qau_pkg::OP_CONJ) && conj_sat;
                        r_stat <= qau_pkg::ST_OK;
                        r_sum <= '0;
                        r_norm <= '0;
                        if (i_in.data.opcode == qau_pkg::OP_LOAD) begin
                            r_acc[0] <= i_in.data.in_w;
                            r_acc[1] <= i_in.data.in_x;
                            r_acc[2] <= i_in.data.in_y;
                            r_acc[3] <= i_in.data.in_z;
                        end else if (i_in.data.opcode == qau_pkg::OP_CONJ) begin
                            for (int k = 1; k < 4; k++) begin
                                r_acc[k] <= qau_pkg::sat16(-48'(r_acc[k]));
                            end
                        end
                    end
                end
                S_PROD: begin
                    if (term == 2'd3) begin
                        r_sum <= '0;
                        if (rnd_ovf) begin
                            r_sat <= 1'b1;
                        end
                        if (r_cnt == 4'd15) begin
                            for (int k = 0; k < 3; k++) begin
                                r_acc[k] <= r_res[k];
                            end
                            r_acc[3] <= rnd_sat;
                        end else begin
                            r_res[comp] <= rnd_sat;
                        end
                    end else begin
                        r_sum <= r_sum + 35'(mul_p);
                    end
                end
                S_NORM: begin
                    if (r_cnt != 4'd4) begin
                        r_norm <= r_norm + 33'(mul_p[31:0]);
                    end else if (r_op == qau_pkg::OP_INV) begin
                        if (r_norm == '0) begin
                            r_stat <= qau_pkg::ST_ZERO;
                        end else begin
                            r_op <= qau_pkg::OP_READ;
                            r_rem <= 33'(dmag[15:2]);
                            r_quo <= '0;
                            r_dividend <= {dmag[1:0], 28'd0};
                        end
                    end
                end
                S_DIV: begin
                    if (r_dcnt == 5'd29) begin
                        if (div_ovf) begin
                            r_sat <= 1'b1;
                        end
                        if (r_cnt != 4'd3) begin
                            r_res[r_cnt[1:0]] <= div_res;
                            r_rem <= 33'(dmag[15:2]);
                            r_quo <= '0;
                            r_dividend <= {dmag[1:0], 28'd0};
                        end else begin
                            for (int k = 0; k < 3; k++) begin
                                r_acc[k] <= r_res[k];
                            end
                            r_acc[3] <= div_res;
                            r_norm <= '0;
                        end
                    end else begin
                        r_rem <= rfin;
                        r_quo <= qfin;
                        r_dividend <= {r_dividend[28:0], 1'b0};
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        r_odata.out_w <= r_acc[0];
                        r_odata.out_x <= r_acc[1];
                        r_odata.out_y <= r_acc[2];
                        r_odata.out_z <= r_acc[3];
                        r_odata.norm_squared <= r_norm;
                        r_odata.status <= (r_stat == qau_pkg::ST_OK && r_sat)
                                          ? qau_pkg::ST_SAT : r_stat;
                    end
                end
                default: ;
            endcase
        end
    end

    assign zero_stat = o_out.valid && (o_out.data.status == qau_pkg::ST_ZERO);
    assign norm_zero = (o_out.data.norm_squared == '0);

    `QAU_ASSERT_IMPL(a_ready_idle, i_clk, i_rst_n, i_in.ready, r_state == S_IDLE, "busy ready")
    `QAU_ASSERT_NEXT(a_done_valid, i_clk, i_rst_n, r_state == S_DONE, o_out.valid, "no result")
    `QAU_ASSERT_NEXT(a_fire_busy, i_clk, i_rst_n, in_fire, !i_in.ready, "double accept")
    `QAU_ASSERT_IMPL(a_zero_status, i_clk, i_rst_n, zero_stat, norm_zero, "zero norm")

endmodule
